@@ sv/qti_pkg.sv @@
// Package for the quintic trajectory interpolator: beat types and constants.
// No dependencies.
package qti_pkg;
  localparam int NUM_COORDS          = 6;
  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int COORD_W             = 32;
  localparam int DUR_W               = 16;
  localparam int ELAPSED_W           = 17;
  localparam int TOL_W               = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              restart;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] target_rot_x;
    logic signed [31:0] target_rot_y;
    logic signed [31:0] target_rot_z;
    logic [15:0]       segment_ticks;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_rot_x;
    logic signed [31:0] pos_rot_y;
    logic signed [31:0] pos_rot_z;
    logic              moving;
    logic              segment_done;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture segment from input beat
    logic div_start; // begin elapsed/duration division
    logic poly_step; // advance polynomial sequence one step
    logic blend_go;  // compute one coordinate
    logic finish;    // advance elapsed, resolve done, fill output
    logic idle_out;  // fill output with held target
  } qti_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic poly_last;
    logic blend_last;
    logic in_motion;
  } qti_sts_t;
endpackage

@@ sv/quintic_trajectory_interpolator_top.sv @@
// Load beats give no result; an idle tick gives its registered result in the cycle after it.
// Moving ticks run the one-bit-per-cycle divider for tau, then the five polynomial
// steps and the blend of each coordinate, and the result then waits while the
// previous result is still held by out_stall. One item in flight at a time.
// Synchronous active-low reset clears start and target poses, counters,
// tolerance (to 1) and state. Depends on qti_pkg, qti_ctrl, qti_datapath.
module quintic_trajectory_interpolator_top #(
  parameter int RATIO_FRAC_BITS = qti_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qti_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qti_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import qti_pkg::*;

  logic [TOL_W-1:0] tol_r;
  qti_cmd_t cmd;
  qti_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= TOL_W'(1);
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  qti_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind(in_data.kind),
    .out_valid, .out_stall, .sts, .cmd
  );

  qti_datapath #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_dp (
    .clk, .rst_n, .in_beat(in_data), .tol(tol_r), .cmd, .sts, .out_beat(out_data)
  );
endmodule

@@ sv/qti_datapath.sv @@
// Datapath: pose storage, serial divider, polynomial and blend unit.
// Depends on qti_pkg.
module qti_datapath #(
  parameter int RATIO_FRAC_BITS = qti_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qti_pkg::in_beat_t   in_beat,
  input  logic [7:0]          tol,
  input  qti_pkg::qti_cmd_t   cmd,
  output qti_pkg::qti_sts_t   sts,
  output qti_pkg::out_beat_t  out_beat
);
  import qti_pkg::*;

  localparam int F    = RATIO_FRAC_BITS;
  localparam int QW   = F + 1;                 // tau, s range 0..2^F
  localparam int NUMW = ELAPSED_W + F;          // dividend width
  localparam int DCW  = $clog2(NUMW + 1);
  localparam int CIW  = (NUM_COORDS > 1) ? $clog2(NUM_COORDS) : 1;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;
  localparam int AW   = F + 5;                  // a up to 10*2^F

  logic signed [COORD_W-1:0] start_r  [NUM_COORDS];
  logic signed [COORD_W-1:0] target_r [NUM_COORDS];
  logic signed [COORD_W-1:0] pos_r    [NUM_COORDS];
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [DUR_W-1:0]     dur_r;
  logic                 motion_r;

  // restoring divider
  logic [NUMW-1:0]  quo_r;
  logic [DUR_W:0]   rem_r;
  logic [DCW-1:0]   dcnt_r;
  logic             dbusy_r;
  logic [DUR_W:0]   rem_sh;
  assign rem_sh = {rem_r[DUR_W-1:0], quo_r[NUMW-1]};

  // polynomial sequence registers
  logic [QW-1:0]  tau_r, t2_r, t3_r, s_r;
  logic [AW-1:0]  a_r;
  logic [2:0]     pstep_r;
  logic [CIW-1:0] ci_r;

  logic signed [COORD_W:0]      diff;
  logic signed [COORD_W+QW+1:0] bprod;
  logic signed [COORD_W:0]      bdelta;
  assign diff   = (COORD_W+1)'(target_r[ci_r]) - (COORD_W+1)'(start_r[ci_r]);
  assign bprod  = (COORD_W+QW+2)'(diff) * $signed({1'b0, s_r});
  assign bdelta = (COORD_W+1)'(bprod >>> F);

  logic [ELAPSED_W-1:0] el_inc;
  logic [DUR_W+1:0] lo_v, hi_v;
  logic done_v;
  assign el_inc = (elapsed_r == {ELAPSED_W{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;
  assign lo_v   = (DUR_W+2)'(dur_r) - (DUR_W+2)'(tol);
  assign hi_v   = (DUR_W+2)'(dur_r) + (DUR_W+2)'(tol);
  assign done_v = ($signed({1'b0, el_inc, 1'b0}) > $signed({lo_v, 1'b0})) &&
                  ({1'b0, el_inc} < hi_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        start_r[i]  <= '0;
        target_r[i] <= '0;
      end
      elapsed_r <= '0;
      dur_r     <= DUR_W'(1);
      motion_r  <= 1'b0;
      dbusy_r   <= 1'b0;
      dcnt_r    <= '0;
      pstep_r   <= '0;
      ci_r      <= '0;
    end else begin
      if (cmd.load) begin
        for (int i = 0; i < NUM_COORDS; i++)
          start_r[i] <= in_beat.restart ? '0 : target_r[i];
        target_r[0] <= in_beat.target_x;
        target_r[1] <= in_beat.target_y;
        target_r[2] <= in_beat.target_z;
        target_r[3] <= in_beat.target_rot_x;
        target_r[4] <= in_beat.target_rot_y;
        target_r[5] <= in_beat.target_rot_z;
        dur_r     <= (in_beat.segment_ticks == '0) ? DUR_W'(1) : in_beat.segment_ticks;
        elapsed_r <= '0;
        motion_r  <= 1'b1;
      end
      if (cmd.div_start) begin
        quo_r   <= {elapsed_r, F'(0)};
        rem_r   <= '0;
        dcnt_r  <= DCW'(NUMW);
        dbusy_r <= 1'b1;
        pstep_r <= '0;
        ci_r    <= '0;
      end else if (dbusy_r) begin
        // one quotient bit per cycle
        if (rem_sh >= {1'b0, dur_r}) begin
          rem_r <= rem_sh - {1'b0, dur_r};
          quo_r <= {quo_r[NUMW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NUMW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == DCW'(1)) dbusy_r <= 1'b0;
      end
      if (cmd.poly_step) begin
        pstep_r <= pstep_r + 1'b1;
        case (pstep_r)
          3'd0: begin
            tau_r <= (quo_r > NUMW'(ONE_Q)) ? ONE_Q : QW'(quo_r);
          end
          3'd1: t2_r <= QW'(((2*AW)'(tau_r) * (2*AW)'(tau_r)) >> F);
          3'd2: t3_r <= QW'(((2*AW)'(t2_r) * (2*AW)'(tau_r)) >> F);
          3'd3: a_r  <= AW'(6) * AW'(t2_r) + (AW'(10) << F) - AW'(15) * AW'(tau_r);
          3'd4: s_r  <= (((2*AW)'(t3_r) * (2*AW)'(a_r)) >> F) > (2*AW)'(ONE_Q) ?
                        ONE_Q : QW'(((2*AW)'(t3_r) * (2*AW)'(a_r)) >> F);
          default: ;
        endcase
      end
      if (cmd.blend_go) begin
        pos_r[ci_r] <= COORD_W'((COORD_W+1)'(start_r[ci_r]) + bdelta);
        ci_r <= ci_r + 1'b1;
      end
      if (cmd.finish) begin
        elapsed_r <= el_inc;
        if (done_v) motion_r <= 1'b0;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_beat.pos_x        <= pos_r[0];
      out_beat.pos_y        <= pos_r[1];
      out_beat.pos_z        <= pos_r[2];
      out_beat.pos_rot_x    <= pos_r[3];
      out_beat.pos_rot_y    <= pos_r[4];
      out_beat.pos_rot_z    <= pos_r[5];
      out_beat.moving       <= ~done_v;
      out_beat.segment_done <= done_v;
    end else if (cmd.idle_out) begin
      out_beat.pos_x        <= target_r[0];
      out_beat.pos_y        <= target_r[1];
      out_beat.pos_z        <= target_r[2];
      out_beat.pos_rot_x    <= target_r[3];
      out_beat.pos_rot_y    <= target_r[4];
      out_beat.pos_rot_z    <= target_r[5];
      out_beat.moving       <= 1'b0;
      out_beat.segment_done <= 1'b0;
    end
  end

  assign sts.div_busy   = dbusy_r;
  assign sts.poly_last  = (pstep_r == 3'd4);
  assign sts.blend_last = (ci_r == CIW'(NUM_COORDS - 1));
  assign sts.in_motion  = motion_r;
endmodule

@@ sv/qti_ctrl.sv @@
// Controller state machine sequencing load, divide, polynomial, blend.
// Depends on qti_pkg.
module qti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  output logic              out_valid,
  input  logic              out_stall,
  input  qti_pkg::qti_sts_t sts,
  output qti_pkg::qti_cmd_t cmd
);
  import qti_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV0  = 6'b000010,
    S_DIV   = 6'b000100,
    S_POLY  = 6'b001000,
    S_BLEND = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept;

  // output register can be refilled once the held beat is taken
  assign in_stall  = (state_r != S_IDLE) || (ovalid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r && out_stall;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load = 1'b1;
          end else if (!sts.in_motion) begin
            cmd.idle_out = 1'b1;
            ovalid_nxt   = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV0;
          end
        end
      end
      S_DIV0: state_nxt = S_DIV;
      S_DIV:  if (!sts.div_busy) state_nxt = S_POLY;
      S_POLY: begin
        cmd.poly_step = 1'b1;
        if (sts.poly_last) state_nxt = S_BLEND;
      end
      S_BLEND: begin
        cmd.blend_go = 1'b1;
        if (sts.blend_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

@@ sv/qti_checker.sv @@
// Port-level checker for the interpolator, bound to the top level.
// Depends on qti_pkg.
module qti_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input qti_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input qti_pkg::out_beat_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.moving && out_data.segment_done))
    else $error("moving and segment_done both set");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.kind && !out_valid |=> !out_valid)
    else $error("load beat produced a result");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind && out_valid |=> in_stall || out_valid)
    else $error("input free with no result delivered");
endmodule

bind quintic_trajectory_interpolator_top qti_checker u_qti_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);

@@ tb/quintic_trajectory_interpolator_top_tb.sv @@
// Self-checking testbench for the quintic trajectory interpolator top level.
// Holds its own trajectory predictor; depends on qti_pkg and the RTL top.
module quintic_trajectory_interpolator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qti_pkg::*;

  localparam int          LIMIT_CYCLES = 3000000;
  localparam int          FRAC         = RATIO_FRAC_BITS_DEF;
  localparam longint      ONE_Q        = longint'(1) << FRAC;
  localparam logic [16:0] ELAPSED_SAT  = 17'h1ffff;
  localparam int          IN_BEAT_W    = $bits(in_beat_t);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  quintic_trajectory_interpolator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic signed [31:0] seg_start [6];
  logic signed [31:0] seg_target[6];
  logic [16:0]        elapsed;
  logic [15:0]        duration;
  logic               in_motion;
  logic [7:0]         tolerance;

  in_beat_t  pending_beats[$];
  out_beat_t expected_poses[$];
  int        errors;
  int        accepted_beats;
  int        cycle_count;
  logic      calm_mode;
  int        long_hold;
  logic      hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned quintic_ratio();
    longint unsigned tau, t2, t3, a, s;
    tau = (longint'(elapsed) << FRAC) / longint'(duration);
    if (tau > ONE_Q) tau = ONE_Q;
    t2 = (tau * tau) >> FRAC;
    t3 = (t2 * tau) >> FRAC;
    a  = 6 * t2 + 10 * ONE_Q - 15 * tau;
    s  = (t3 * a) >> FRAC;
    if (s > ONE_Q) s = ONE_Q;
    return s;
  endfunction

  function automatic logic [31:0] blend_coord(logic signed [31:0] from,
                                              logic signed [31:0] to,
                                              longint unsigned s);
    longint diff, prod;
    diff = longint'(to) - longint'(from);
    prod = diff * longint'(s);
    return 32'(longint'(from) + (prod >>> FRAC));
  endfunction

  task automatic advance_trajectory(input in_beat_t b);
    out_beat_t       r;
    logic [31:0]     p[6];
    longint unsigned s;
    int              lo, hi;
    logic            done;
    if (b.kind == KIND_LOAD) begin
      seg_start[0] = b.restart ? '0 : seg_target[0];
      seg_start[1] = b.restart ? '0 : seg_target[1];
      seg_start[2] = b.restart ? '0 : seg_target[2];
      seg_start[3] = b.restart ? '0 : seg_target[3];
      seg_start[4] = b.restart ? '0 : seg_target[4];
      seg_start[5] = b.restart ? '0 : seg_target[5];
      seg_target[0] = b.target_x;
      seg_target[1] = b.target_y;
      seg_target[2] = b.target_z;
      seg_target[3] = b.target_rot_x;
      seg_target[4] = b.target_rot_y;
      seg_target[5] = b.target_rot_z;
      duration  = (b.segment_ticks == 0) ? 16'd1 : b.segment_ticks;
      elapsed   = '0;
      in_motion = 1'b1;
      return;
    end
    done = 1'b0;
    if (!in_motion) begin
      for (int i = 0; i < 6; i++) p[i] = seg_target[i];
    end else begin
      s = quintic_ratio();
      for (int i = 0; i < 6; i++) p[i] = blend_coord(seg_start[i], seg_target[i], s);
      if (elapsed < ELAPSED_SAT) elapsed = elapsed + 1'b1;
      lo = int'(duration) - int'(tolerance);
      hi = int'(duration) + int'(tolerance);
      done = (int'(elapsed) > lo) && (int'(elapsed) < hi);
      if (done) in_motion = 1'b0;
    end
    r.pos_x = p[0]; r.pos_y = p[1]; r.pos_z = p[2];
    r.pos_rot_x = p[3]; r.pos_rot_y = p[4]; r.pos_rot_z = p[5];
    r.moving = in_motion;
    r.segment_done = done;
    expected_poses.push_back(r);
  endtask

  function automatic int pick_gap();
    if (calm_mode || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: hold a beat until taken, then pop the next one after a gap.
  int       gap_left;
  in_beat_t next_beat;
  always @(posedge clk) begin
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        advance_trajectory(in_data);
        accepted_beats <= accepted_beats + 1;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          next_beat = pending_beats.pop_front();
          in_valid <= 1'b1;
          in_data  <= next_beat;
          gap_left <= pick_gap();
        end
      end
    end
  end

  // Receiver stall: random stalls and hold-offs, with one long hold-off once traffic is under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 0;
      hold_done <= 1'b0;
    end else if (long_hold > 0) begin
      out_stall <= 1'b1;
      long_hold <= long_hold - 1;
    end else if (!hold_done && accepted_beats > 300) begin
      out_stall <= 1'b1;
      long_hold <= 600;
      hold_done <= 1'b1;
    end else if (!calm_mode && $urandom_range(0, 99) == 0) begin
      out_stall <= 1'b1;
      long_hold <= $urandom_range(10, 60);
    end else begin
      out_stall <= !calm_mode && ($urandom_range(0, 9) < 3);
    end
  end

  // Monitor
  always @(posedge clk) begin
    out_beat_t   e;
    logic [31:0] got[8], want[8];
    string       names[8];
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        errors++;
      end else begin
        e = expected_poses.pop_front();
        names = '{"pos_x", "pos_y", "pos_z", "pos_rot_x", "pos_rot_y", "pos_rot_z",
                  "moving", "segment_done"};
        got  = '{out_data.pos_x, out_data.pos_y, out_data.pos_z, out_data.pos_rot_x,
                 out_data.pos_rot_y, out_data.pos_rot_z, 32'(out_data.moving),
                 32'(out_data.segment_done)};
        want = '{e.pos_x, e.pos_y, e.pos_z, e.pos_rot_x, e.pos_rot_y, e.pos_rot_z,
                 32'(e.moving), 32'(e.segment_done)};
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: %s expected %h actual %h", $time, names[i], want[i], got[i]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 3000 == 2999) calm_mode <= $urandom_range(0, 3) == 0;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t load_beat(logic restart, logic [15:0] ticks);
    in_beat_t b;
    b.kind = KIND_LOAD;
    b.restart = restart;
    b.target_x = pick_coord(); b.target_y = pick_coord(); b.target_z = pick_coord();
    b.target_rot_x = pick_coord(); b.target_rot_y = pick_coord();
    b.target_rot_z = pick_coord();
    b.segment_ticks = ticks;
    return b;
  endfunction

  // Tick beats carry random junk in the unused fields.
  function automatic in_beat_t tick_beat();
    in_beat_t b;
    b = IN_BEAT_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom});
    b.kind = KIND_TICK;
    return b;
  endfunction

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) pending_beats.push_back(tick_beat());
  endtask

  task automatic drain_all();
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_poses.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    tolerance = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic queue_random_segments(int n_items);
    int       n, dur;
    in_beat_t b;
    n = 0;
    while (n < n_items) begin
      case ($urandom_range(0, 9))
        0: begin                          // noise: stray ticks
          queue_ticks($urandom_range(1, 4));
          n += 2;
        end
        1: begin                          // broken: reload before the segment ends
          pending_beats.push_back(load_beat(1'($urandom_range(0, 1)),
                                            16'($urandom_range(5, 30))));
          queue_ticks($urandom_range(1, 3));
          n += 3;
        end
        default: begin
          dur = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24);
          b = load_beat($urandom_range(0, 3) == 0, 16'(dur));
          pending_beats.push_back(b);
          dur = (b.segment_ticks > 24) ? $urandom_range(1, 8) : int'(b.segment_ticks);
          queue_ticks(dur + $urandom_range(0, 3));
          n += dur + 2;
        end
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    accepted_beats = 0;
    cycle_count = 0;
    calm_mode = 1'b0;
    for (int i = 0; i < 6; i++) begin
      seg_start[i] = '0;
      seg_target[i] = '0;
    end
    elapsed = '0;
    duration = 16'd1;
    in_motion = 1'b0;
    tolerance = 8'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: idle tick from reset, zero duration, both extremes, restart.
    queue_ticks(1);
    pending_beats.push_back('{KIND_LOAD, 1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                              32'h8000_0000, 32'h0, 32'hffff_ffff, 16'h0});
    queue_ticks(2);
    pending_beats.push_back('{KIND_LOAD, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                              32'h7fff_ffff, 32'h0001_0000, 32'h0, 16'd3});
    queue_ticks(4);
    pending_beats.push_back('{KIND_LOAD, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                              32'hedcb_a988, 32'h7fff_ffff, 32'h8000_0000, 16'hffff});
    queue_ticks(2);
    drain_all();

    // Wide window: the first tick closes the segment.
    write_tolerance(8'd255);
    pending_beats.push_back(load_beat(1'b0, 16'd5));
    queue_ticks(3);
    drain_all();

    // Empty window: motion never ends on its own.
    write_tolerance(8'd0);
    pending_beats.push_back(load_beat(1'b1, 16'd2));
    queue_ticks(6);
    drain_all();

    write_tolerance(8'd1);
    queue_random_segments(260);
    drain_all();
    write_tolerance(8'($urandom_range(2, 6)));
    queue_random_segments(240);
    drain_all();
    write_tolerance(8'd255);
    queue_random_segments(100);
    drain_all();
    write_tolerance(8'($urandom_range(1, 254)));
    queue_random_segments(130);
    drain_all();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/qti_pkg.sv
sv/qti_datapath.sv
sv/qti_ctrl.sv
sv/quintic_trajectory_interpolator_top.sv
sv/qti_checker.sv
tb/quintic_trajectory_interpolator_top_tb.sv
